[design/mlzbd_pkg.sv]
// ----------------------------------------------------------------------------
// mlzbd_pkg
// Shared types and constants for the marker LZ backward decompressor.
// ----------------------------------------------------------------------------
package mlzbd_pkg;

    localparam logic [15:0] C_MAX_OUTPUT = 16'hC000;
    localparam logic [5:0]  C_MIN_MATCH  = 6'd3;

    typedef enum logic [2:0] {
        S_TOKEN,
        S_LEN,
        S_DIST,
        S_COPY,
        S_HALT
    } t_state;

    typedef struct packed {
        logic lit_push;
        logic lit_sel_marker;
        logic lit_done;
        logic hold_len;
        logic copy_start;
        logic copy_from_len;
        logic copy_fin;
        logic copy_issue;
        logic err_push;
    } t_dp_cmd;

    typedef struct packed {
        logic is_marker;
        logic is_zero;
        logic bad_now;
        logic bad_held;
        logic hits_max;
        logic last_issue;
        logic copy_done;
        logic space;
        logic inflight;
    } t_dp_stat;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       status;
    } t_out_item;

endpackage

[design/mlzbd_ram.sv]
// ----------------------------------------------------------------------------
// mlzbd_ram
// Simple dual-port RAM, one write and one registered read, old data on a
// read of the address being written.
// ----------------------------------------------------------------------------
module mlzbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wen,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/mlzbd_datapath.sv]
// ----------------------------------------------------------------------------
// mlzbd_datapath
// Marker register, history window, copy pointers, produced count and a
// two-entry output queue.
// ----------------------------------------------------------------------------
module mlzbd_datapath
    import mlzbd_pkg::*;
#(
    parameter int WINDOW_BYTES = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wen,
    input  logic [7:0] i_cfg_wdata,
    input  logic [7:0] i_byte,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,
    output logic       o_m_axis_tlast,
    output logic [1:0] o_m_axis_tuser
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam logic [AW:0]   C_WIN  = (AW+1)'(WINDOW_BYTES);
    localparam logic [AW-1:0] C_WTOP = AW'(WINDOW_BYTES - 1);

    function automatic logic [11:0] f_dist(input logic [7:0] n, input logic [7:0] b);
        return {1'b0, n[2:0], b} + 12'd1;
    endfunction

    logic [7:0]    r_marker;
    logic [7:0]    r_len;
    logic [15:0]   r_count;
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [5:0]    r_remain;
    logic          r_dist_one;
    logic [7:0]    r_last_byte;
    logic          r_copy_done;
    logic          r_inflight;
    logic          r_if_last;
    t_out_item     r_fifo [2];
    logic          r_rd_idx;
    logic          r_wr_idx;
    logic [1:0]    r_fcount;

    logic [7:0]    ram_rdata;
    logic [7:0]    cp_n;
    logic [7:0]    cp_b;
    logic [11:0]   cp_dist;
    logic [5:0]    cp_len;
    logic [15:0]   rem_out;
    logic [AW:0]   wide_wptr;
    logic [AW:0]   wide_dist;
    logic [AW:0]   start_rptr;
    logic          wen;
    logic [7:0]    wbyte;
    logic          push;
    t_out_item     push_item;
    logic          pop;
    logic [2:0]    occ;

    mlzbd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_hist (
        .i_clk   (i_clk),
        .i_wen   (wen),
        .i_waddr (r_wptr),
        .i_wdata (wbyte),
        .i_raddr (r_rptr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cp_n       = i_cmd.copy_from_len ? i_byte : r_len;
        cp_b       = i_cmd.copy_from_len ? 8'd0 : i_byte;
        cp_dist    = f_dist(cp_n, cp_b);
        cp_len     = 6'(cp_n[7:3]) + C_MIN_MATCH;
        rem_out    = C_MAX_OUTPUT - r_count;
        wide_wptr  = {1'b0, r_wptr};
        wide_dist  = (AW+1)'(cp_dist);
        if (wide_wptr >= wide_dist) begin
            start_rptr = wide_wptr - wide_dist;
        end else begin
            start_rptr = wide_wptr + C_WIN - wide_dist;
        end

        wen   = i_cmd.lit_push || r_inflight;
        wbyte = r_inflight ? (r_dist_one ? r_last_byte : ram_rdata)
                           : (i_cmd.lit_sel_marker ? r_marker : i_byte);

        push = wen || i_cmd.err_push;
        if (i_cmd.err_push) begin
            push_item = '{data: 8'd0, last: 1'b1, done: 1'b1, status: 1'b1};
        end else if (r_inflight) begin
            push_item = '{data: wbyte, last: r_if_last,
                          done: r_if_last && r_copy_done, status: 1'b0};
        end else begin
            push_item = '{data: wbyte, last: 1'b1, done: i_cmd.lit_done, status: 1'b0};
        end

        pop = (r_fcount != 2'd0) && i_m_axis_tready;
        occ = {1'b0, r_fcount} + {2'b00, r_inflight};

        o_stat.is_marker  = (i_byte == r_marker);
        o_stat.is_zero    = (i_byte == 8'd0);
        o_stat.bad_now    = 16'(f_dist(i_byte, 8'd0)) > r_count;
        o_stat.bad_held   = 16'(f_dist(r_len, i_byte)) > r_count;
        o_stat.hits_max   = (r_count == C_MAX_OUTPUT - 16'd1);
        o_stat.last_issue = (r_remain == 6'd1);
        o_stat.copy_done  = r_copy_done;
        o_stat.space      = occ <= (3'd1 + {2'b00, pop});
        o_stat.inflight   = r_inflight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker   <= 8'd0;
            r_len      <= 8'd0;
            r_count    <= 16'd0;
            r_wptr     <= '0;
            r_remain   <= 6'd0;
            r_inflight <= 1'b0;
            r_rd_idx   <= 1'b0;
            r_wr_idx   <= 1'b0;
            r_fcount   <= 2'd0;
        end else begin
            if (i_cfg_wen) begin
                r_marker <= i_cfg_wdata;
            end
            if (i_cmd.hold_len) begin
                r_len <= i_byte;
            end
            if (wen) begin
                r_count <= r_count + 16'd1;
                r_wptr  <= (r_wptr == C_WTOP) ? '0 : r_wptr + AW'(1);
            end
            if (i_cmd.copy_start) begin
                r_remain <= (rem_out < 16'(cp_len)) ? rem_out[5:0] : cp_len;
            end else if (i_cmd.copy_issue) begin
                r_remain <= r_remain - 6'd1;
            end
            r_inflight <= i_cmd.copy_issue;
            if (push) begin
                r_wr_idx <= ~r_wr_idx;
            end
            if (pop) begin
                r_rd_idx <= ~r_rd_idx;
            end
            r_fcount <= r_fcount + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_last_byte <= wbyte;
        end
        if (i_cmd.copy_start) begin
            r_rptr      <= start_rptr[AW-1:0];
            r_dist_one  <= (cp_dist == 12'd1);
            r_copy_done <= i_cmd.copy_fin || (rem_out <= 16'(cp_len));
        end else if (i_cmd.copy_issue) begin
            r_rptr <= (r_rptr == C_WTOP) ? '0 : r_rptr + AW'(1);
        end
        if (i_cmd.copy_issue) begin
            r_if_last <= (r_remain == 6'd1);
        end
        if (push) begin
            r_fifo[r_wr_idx] <= push_item;
        end
    end

    assign o_m_axis_tvalid = (r_fcount != 2'd0);
    assign o_m_axis_tdata  = r_fifo[r_rd_idx].data;
    assign o_m_axis_tlast  = r_fifo[r_rd_idx].last;
    assign o_m_axis_tuser  = {r_fifo[r_rd_idx].status, r_fifo[r_rd_idx].done};

endmodule

[design/mlzbd_ctrl.sv]
// ----------------------------------------------------------------------------
// mlzbd_ctrl
// Token parser and copy sequencer for the marker LZ backward decompressor.
// ----------------------------------------------------------------------------
module mlzbd_ctrl
    import mlzbd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    input  logic     i_s_axis_tlast,
    output logic     o_s_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   ready;
    logic   acc;
    logic   lit_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TOKEN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        ready    = 1'b0;
        lit_done = i_s_axis_tlast || i_stat.hits_max;
        unique case (r_state)
            S_TOKEN, S_LEN, S_DIST: ready = i_stat.space && !i_stat.inflight;
            S_HALT:                 ready = 1'b1;
            S_COPY:                 ready = 1'b0;
            default:                ready = 1'b0;
        endcase
        acc = i_s_axis_tvalid && ready;

        unique case (r_state)
            S_TOKEN: begin
                if (acc) begin
                    if (!i_stat.is_marker || i_s_axis_tlast) begin
                        o_cmd.lit_push = 1'b1;
                        o_cmd.lit_done = lit_done;
                        n_state        = lit_done ? S_HALT : S_TOKEN;
                    end else begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (acc) begin
                    if (i_stat.is_zero) begin
                        o_cmd.lit_push       = 1'b1;
                        o_cmd.lit_sel_marker = 1'b1;
                        o_cmd.lit_done       = lit_done;
                        n_state              = lit_done ? S_HALT : S_TOKEN;
                    end else if (i_s_axis_tlast) begin
                        if (i_stat.bad_now) begin
                            o_cmd.err_push = 1'b1;
                            n_state        = S_HALT;
                        end else begin
                            o_cmd.copy_start    = 1'b1;
                            o_cmd.copy_from_len = 1'b1;
                            o_cmd.copy_fin      = 1'b1;
                            n_state             = S_COPY;
                        end
                    end else begin
                        o_cmd.hold_len = 1'b1;
                        n_state        = S_DIST;
                    end
                end
            end
            S_DIST: begin
                if (acc) begin
                    if (i_stat.bad_held) begin
                        o_cmd.err_push = 1'b1;
                        n_state        = S_HALT;
                    end else begin
                        o_cmd.copy_start = 1'b1;
                        o_cmd.copy_fin   = i_s_axis_tlast;
                        n_state          = S_COPY;
                    end
                end
            end
            S_COPY: begin
                if (i_stat.space) begin
                    o_cmd.copy_issue = 1'b1;
                    if (i_stat.last_issue) begin
                        n_state = i_stat.copy_done ? S_HALT : S_TOKEN;
                    end
                end
            end
            S_HALT: begin
                n_state = S_HALT;
            end
            default: begin
                n_state = S_TOKEN;
            end
        endcase
    end

    assign o_s_axis_tready = ready;

endmodule

[design/marker_lz_backward_decompressor_core.sv]
// A literal request is registered into the output queue when it is taken.
// Throughput: one literal or token byte per cycle while the queue has space and
// no copy byte is in flight; a copy holds the input until its last RAM read.
// The two-entry output queue lets decoding continue while a result waits.
// Reset is synchronous and active low; it clears all control state and the
// marker register, whilst the history contents stay undefined until written.
// ----------------------------------------------------------------------------
// marker_lz_backward_decompressor_core
// Top level: decodes marker LZ packed bytes, supplied back to front, into
// decoded bytes in decode order.
// ----------------------------------------------------------------------------
module marker_lz_backward_decompressor_core
    import mlzbd_pkg::*;
#(
    parameter int WINDOW_BYTES = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wen,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] packed_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] out_byte
    output logic       o_m_axis_tlast,
    output logic [1:0] o_m_axis_tuser   // [0] stream_done, [1] status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mlzbd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    mlzbd_datapath #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_byte          (i_s_axis_tdata),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

[tb/mlzbd_decode_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlzbd_decode_monitor
// Watches the configuration port and both streams of the marker LZ backward
// decompressor, works out the decoded bytes that every accepted request
// should yield and compares each delivered byte with the oldest one due.
// ----------------------------------------------------------------------------
module mlzbd_decode_monitor
    import mlzbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] packed_byte
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [7:0] out_byte
    input  logic        i_m_tlast,
    input  logic [1:0]  i_m_tuser,   // [0] stream_done, [1] status
    output int          o_fail_count,
    output int          o_pending,
    output int          o_accepted,
    output int          o_checked,
    output logic        o_halted,
    output logic [15:0] o_produced
);

    logic [7:0]  marker;
    t_state      phase;
    logic [7:0]  held_len;
    logic [15:0] produced;
    logic [7:0]  hist [0:2047];
    logic [10:0] wr_ptr;
    logic        halted;
    t_out_item   decoded_due [$];
    t_out_item   seen;
    t_out_item   due;
    int          fails = 0;
    int          accepted = 0;
    int          checked = 0;

    task automatic record_byte(input logic [7:0] v);
        t_out_item item;
        item.data   = v;
        item.last   = 1'b0;
        item.done   = 1'b0;
        item.status = 1'b0;
        decoded_due.push_back(item);
        hist[wr_ptr] = v;
        wr_ptr   = wr_ptr + 11'd1;
        produced = produced + 16'd1;
    endtask

    task automatic copy_history(input logic [7:0] n, input logic [7:0] b, output logic bad);
        logic [5:0]  len;
        logic [11:0] back_dist;
        logic [10:0] pos;
        len       = C_MIN_MATCH + {1'b0, n[7:3]};
        back_dist = {1'b0, n[2:0], b} + 12'd1;
        bad       = ({4'd0, back_dist} > produced);
        if (!bad) begin
            for (int i = 0; i < int'(len) && produced < C_MAX_OUTPUT; i++) begin
                pos = wr_ptr - back_dist[10:0];
                record_byte(hist[pos]);
            end
        end
    endtask

    task automatic decode_packed_byte(input logic [7:0] pb, input logic fin);
        logic      bad;
        int        first;
        t_out_item item;
        bad   = 1'b0;
        first = decoded_due.size();
        if (!halted) begin
            case (phase)
                S_LEN: begin
                    if (pb == 8'd0) begin
                        record_byte(marker);
                    end else if (fin) begin
                        copy_history(pb, 8'd0, bad);
                    end else begin
                        held_len = pb;
                    end
                    phase = (pb != 8'd0 && !fin) ? S_DIST : S_TOKEN;
                end
                S_DIST: begin
                    copy_history(held_len, pb, bad);
                    phase = S_TOKEN;
                end
                default: begin
                    phase = S_TOKEN;
                    if (pb != marker) begin
                        record_byte(pb);
                    end else if (fin) begin
                        record_byte(marker);
                    end else begin
                        phase = S_LEN;
                    end
                end
            endcase
            if (bad) begin
                item.data   = 8'd0;
                item.last   = 1'b1;
                item.done   = 1'b1;
                item.status = 1'b1;
                decoded_due.push_back(item);
                halted = 1'b1;
            end else begin
                if (fin || produced >= C_MAX_OUTPUT) begin
                    halted = 1'b1;
                end
                if (decoded_due.size() > first) begin
                    item      = decoded_due.pop_back();
                    item.last = 1'b1;
                    item.done = halted;
                    decoded_due.push_back(item);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            marker   = 8'd0;
            phase    = S_TOKEN;
            held_len = 8'd0;
            produced = 16'd0;
            wr_ptr   = 11'd0;
            halted   = 1'b0;
            decoded_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.data   = i_m_tdata;
                seen.last   = i_m_tlast;
                seen.done   = i_m_tuser[0];
                seen.status = i_m_tuser[1];
                if (decoded_due.size() == 0) begin
                    fails++;
                    $display("%0t ns: unexpected byte, expected none, %s %02h %s %0b %s %0b %s %0b",
                             $time, "got data", seen.data, "last", seen.last,
                             "done", seen.done, "status", seen.status);
                end else begin
                    due = decoded_due.pop_front();
                    checked++;
                    if (seen !== due) begin
                        fails++;
                        $display("%0t ns: expected data %02h last %0b done %0b status %0b,",
                                 $time, due.data, due.last, due.done, due.status);
                        $display("    got data %02h last %0b done %0b status %0b",
                                 seen.data, seen.last, seen.done, seen.status);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                accepted++;
                decode_packed_byte(i_s_tdata, i_s_tlast);
            end
            if (i_cfg_wen) begin
                marker = i_cfg_wdata;
            end
        end
        o_fail_count <= fails;
        o_pending    <= decoded_due.size();
        o_accepted   <= accepted;
        o_checked    <= checked;
        o_halted     <= halted;
        o_produced   <= produced;
    end

endmodule

[tb/marker_lz_backward_decompressor_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_lz_backward_decompressor_core_tb
// Feeds packed bytes to the decompressor under several marker settings: a
// short directed opening, then random token streams with legal distances and
// stray bytes, with random gaps on both streams, and finally one of the ways
// a stream can end. A separate monitor predicts and checks every decoded byte.
// ----------------------------------------------------------------------------
module marker_lz_backward_decompressor_core_tb;
    import mlzbd_pkg::*;

    localparam int RELAX_CYCLES = 40;
    localparam int WINDOW       = 2048;

    localparam logic [7:0] OPEN_ZERO [17] = '{
        8'h01, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA,
        8'h00, 8'h00,
        8'h00, 8'h08, 8'h00,
        8'h00, 8'h10, 8'h0A,
        8'h00, 8'hF8, 8'h0F
    };
    localparam logic [7:0] OPEN_ALL_ONES [7] = '{
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'h18, 8'h02, 8'hFE
    };

    typedef enum int {
        END_LITERAL,
        END_MARKER,
        END_LENGTH,
        END_DISTANCE,
        END_BAD_DISTANCE,
        END_LIMIT
    } t_ending;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wen = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    int          mon_fails;
    int          mon_pending;
    int          mon_accepted;
    int          mon_checked;
    logic        mon_halted;
    logic [15:0] mon_produced;

    logic        steady = 1'b0;
    int          stall_left = 0;
    logic [7:0]  tx_marker = 8'd0;
    t_state      tx_phase = S_TOKEN;
    logic [7:0]  tx_held = 8'd0;
    int          tx_items = 0;
    int          settings = 1;

    always #10 clk = ~clk;

    marker_lz_backward_decompressor_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    mlzbd_decode_monitor u_decode_mon (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wen    (cfg_wen),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_fail_count (mon_fails),
        .o_pending    (mon_pending),
        .o_accepted   (mon_accepted),
        .o_checked    (mon_checked),
        .o_halted     (mon_halted),
        .o_produced   (mon_produced)
    );

    always @(posedge clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!steady && $urandom_range(0, 99) < 4) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] other_byte();
        logic [7:0] v;
        v = 8'($urandom);
        while (v == tx_marker) begin
            v = 8'($urandom);
        end
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] pb, input logic fin);
        if (!steady && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pb;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tx_items++;
        case (tx_phase)
            S_LEN: begin
                tx_held  = pb;
                tx_phase = (pb != 8'd0 && !fin) ? S_DIST : S_TOKEN;
            end
            S_DIST: tx_phase = S_TOKEN;
            default: tx_phase = (pb == tx_marker && !fin) ? S_LEN : S_TOKEN;
        endcase
    endtask

    task automatic let_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (mon_pending != 0) @(posedge clk);
        repeat (RELAX_CYCLES) @(posedge clk);
    endtask

    task automatic set_marker(input logic [7:0] m);
        cfg_wen   <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        tx_marker = m;
        settings++;
    endtask

    task automatic encode_copy(input int unsigned back_dist, input int unsigned code,
                               output logic [7:0] n, output logic [7:0] b);
        if (code == 0 && back_dist <= 256) begin
            code = 1;
        end
        n = {code[4:0], 3'((back_dist - 1) >> 8)};
        b = 8'(back_dist - 1);
    endtask

    // The produced count seen here may lag by one request, which only makes
    // the chosen distance more cautious.
    task automatic random_copy(input int unsigned min_code,
                               output logic [7:0] n, output logic [7:0] b);
        int unsigned reach;
        reach = mon_produced;
        if (reach > WINDOW) begin
            reach = WINDOW;
        end
        if (reach > 8 && $urandom_range(0, 1) == 1) begin
            reach = 8;
        end
        encode_copy($urandom_range(1, reach), $urandom_range(min_code, 31), n, b);
    endtask

    task automatic loose_byte(output logic [7:0] v);
        int hi_cap;
        int span;
        v = 8'($urandom);
        case (tx_phase)
            S_LEN: begin
                if (v != 8'd0) begin
                    if (mon_produced == 16'd0) begin
                        v = 8'd0;
                    end else begin
                        hi_cap = (int'(mon_produced) - 1) >> 8;
                        if (hi_cap > 7) begin
                            hi_cap = 7;
                        end
                        v[2:0] = 3'($urandom_range(0, hi_cap));
                    end
                end
            end
            S_DIST: begin
                span = int'(mon_produced) - 1 - 256 * int'(tx_held[2:0]);
                if (span > 255) begin
                    span = 255;
                end
                v = 8'($urandom_range(0, span));
            end
            default: ;
        endcase
    endtask

    task automatic random_token();
        int unsigned pick;
        logic [7:0]  n;
        logic [7:0]  b;
        logic [7:0]  v;
        pick = $urandom_range(0, 99);
        if (tx_phase != S_TOKEN) begin
            loose_byte(v);
            send_byte(v, 1'b0);
        end else if (pick < 35) begin
            send_byte(other_byte(), 1'b0);
        end else if (pick < 45) begin
            send_byte(tx_marker, 1'b0);
            send_byte(8'd0, 1'b0);
        end else if (pick < 85) begin
            random_copy(0, n, b);
            send_byte(tx_marker, 1'b0);
            send_byte(n, 1'b0);
            send_byte(b, 1'b0);
        end else if (pick < 95) begin
            loose_byte(v);
            send_byte(v, 1'b0);
        end else begin
            send_byte(tx_marker, 1'b0);
        end
    endtask

    initial begin
        t_ending     ending;
        string       ending_text;
        logic [7:0]  n;
        logic [7:0]  b;
        logic [7:0]  v;
        int unsigned goal;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPEN_ZERO[i]) send_byte(OPEN_ZERO[i], 1'b0);
        let_drain();
        set_marker(8'hFF);
        foreach (OPEN_ALL_ONES[i]) send_byte(OPEN_ALL_ONES[i], 1'b0);

        for (int ph = 0; ph < 5; ph++) begin
            let_drain();
            case (ph)
                1: set_marker(8'h00);
                3: set_marker(8'hFF);
                default: set_marker(8'($urandom));
            endcase
            steady <= (ph == 2);
            goal = tx_items + 65;
            while (tx_items < goal) random_token();
        end
        steady <= 1'b0;
        while (tx_phase != S_TOKEN) begin
            loose_byte(v);
            send_byte(v, 1'b0);
        end

        ending = t_ending'($urandom_range(0, 5));
        case (ending)
            END_LITERAL: begin
                ending_text = "a final literal";
                send_byte(other_byte(), 1'b1);
            end
            END_MARKER: begin
                ending_text = "a final lone marker";
                send_byte(tx_marker, 1'b1);
            end
            END_LENGTH: begin
                ending_text = "a final length byte";
                random_copy(1, n, b);
                send_byte(tx_marker, 1'b0);
                send_byte(n, 1'b1);
            end
            END_DISTANCE: begin
                ending_text = "a final distance byte";
                random_copy(0, n, b);
                send_byte(tx_marker, 1'b0);
                send_byte(n, 1'b0);
                send_byte(b, 1'b1);
            end
            END_BAD_DISTANCE: begin
                let_drain();
                if (mon_produced < 16'(WINDOW)) begin
                    ending_text = "a distance beyond the decoded bytes";
                    encode_copy($urandom_range(int'(mon_produced) + 1, WINDOW),
                                $urandom_range(0, 31), n, b);
                    send_byte(tx_marker, 1'b0);
                    send_byte(n, 1'b0);
                    send_byte(b, 1'($urandom_range(0, 1)));
                end else begin
                    ending_text = "a final escaped marker";
                    send_byte(tx_marker, 1'b0);
                    send_byte(8'd0, 1'b1);
                end
            end
            default: begin
                ending_text = "the output byte limit";
                while (!mon_halted) begin
                    random_copy(24, n, b);
                    send_byte(tx_marker, 1'b0);
                    send_byte(n, 1'b0);
                    send_byte(b, 1'b0);
                end
            end
        endcase
        let_drain();

        $display("Summary: %0d packed bytes taken and %0d decoded bytes checked",
                 mon_accepted, mon_checked);
        $display("over %0d marker settings.", settings);
        $display("The stream was closed by %s.", ending_text);
        if (mon_fails == 0 && mon_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timed out with %0d decoded bytes still due.", mon_pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

[marker_lz_backward_decompressor_core.f]
design/mlzbd_pkg.sv
design/mlzbd_ram.sv
design/mlzbd_datapath.sv
design/mlzbd_ctrl.sv
design/marker_lz_backward_decompressor_core.sv
tb/mlzbd_decode_monitor.sv
tb/marker_lz_backward_decompressor_core_tb.sv
